// ===== hdl/pttw_pkg.sv =====
// Shared types and constants for the page table walk block.
`default_nettype none
package pttw_pkg;

  localparam int WORD_W = 46;
  localparam int VA_W = 30;
  localparam int PA_W = 48;
  localparam int DESC_W = 64;
  localparam int WIDX_W = 12;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_XLATE = 1'b1;

  localparam logic REG_USER_BASE = 1'b0;
  localparam logic REG_KERNEL_BASE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [VA_W-1:0]   va;
    logic [WORD_W-1:0] word;
    logic              oob;
    logic [DESC_W-1:0] data;
  } req_t;

endpackage
`default_nettype wire

// ===== hdl/pttw_in_if.sv =====
// Request channel carrying table writes and translations.
`default_nettype none
interface pttw_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] virt_addr;
  logic [11:0] word_index;
  logic [63:0] entry_data;

  modport source(output valid, output action, output virt_addr, output word_index,
                 output entry_data, input ready);
  modport sink(input valid, input action, input virt_addr, input word_index,
               input entry_data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pttw_out_if.sv =====
// Result channel carrying translated addresses and faults.
`default_nettype none
interface pttw_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] phys_addr;
  logic        fault;

  modport source(output valid, output phys_addr, output fault, input ready);
  modport sink(input valid, input phys_addr, input fault, output ready);
endinterface
`default_nettype wire

// ===== hdl/pttw_cfg_if.sv =====
// Configuration write channel for the table base registers.
`default_nettype none
interface pttw_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [47:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/page_table_walk_translate.sv =====
// Three-level page table walker with its own descriptor memory.
// Requests arrive on in_chan: action 0 stores entry_data at word_index of the
// table memory and gives no result; action 1 translates virt_addr and gives
// one result on out_chan (phys_addr, or fault with phys_addr zero).
// cfg_chan writes the user (index 0) and kernel (index 1) level-1 table bases;
// it is always ready. The user must write it only while no request is in
// flight; the block does not enforce this. A translation is taken from the
// queue as the walker issues its level-1 read (a level-1 entry outside the
// memory faults in that cycle), then walks one level per registered read of
// the table memory. A table write is done as the walker takes it.
// A two-entry queue separates request acceptance from the walker, so requests
// are taken while a walk or a held result is pending, until the queue is full.
// After reset the table memory is cleared one word per cycle, all TABLE_WORDS
// words; in_chan.ready stays low until the sweep ends.
// A stalled result is held in the output register; the walker holds once it has a result of its own.
`default_nettype none
module page_table_walk_translate #(
  parameter int TABLE_WORDS = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pttw_cfg_if.sink   cfg_chan,
  pttw_in_if.sink    in_chan,
  pttw_out_if.source out_chan
);

  logic           clearing;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  pttw_pkg::req_t q_push_data;
  pttw_pkg::req_t q_pop_data;

  pttw_front #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_chan(cfg_chan),
    .in_chan (in_chan),
    .clearing(clearing),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_push_data)
  );

  pttw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .not_empty(q_valid)
  );

  pttw_back #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .clearing(clearing),
    .out_chan(out_chan)
  );

endmodule
`default_nettype wire

// ===== hdl/pttw_front.sv =====
// Front end: base registers, request acceptance and classification.
`default_nettype none
module pttw_front #(
  parameter int TABLE_WORDS = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  pttw_cfg_if.sink           cfg_chan,
  pttw_in_if.sink            in_chan,
  input  wire logic          clearing,
  input  wire logic          q_full,
  output logic               q_push,
  output pttw_pkg::req_t     q_data
);

  localparam logic [pttw_pkg::WORD_W-1:0] TW_EXT = pttw_pkg::WORD_W'(TABLE_WORDS);

  logic [pttw_pkg::PA_W-1:0] user_base_r;
  logic [pttw_pkg::PA_W-1:0] kernel_base_r;
  logic [pttw_pkg::PA_W-1:0] base;
  logic [pttw_pkg::WORD_W-1:0] l1_word;
  logic [pttw_pkg::WORD_W-1:0] wr_word;
  logic wr_drop;
  logic accept;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_base_r   <= '0;
      kernel_base_r <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        pttw_pkg::REG_USER_BASE:   user_base_r   <= cfg_chan.data;
        pttw_pkg::REG_KERNEL_BASE: kernel_base_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign base    = (|in_chan.virt_addr[63:48]) ? kernel_base_r : user_base_r;
  assign l1_word = pttw_pkg::WORD_W'(base[47:3]) + pttw_pkg::WORD_W'(in_chan.virt_addr[38:30]);
  assign wr_word = pttw_pkg::WORD_W'(in_chan.word_index);
  assign wr_drop = (in_chan.action == pttw_pkg::KIND_WRITE) && (wr_word >= TW_EXT);

  assign in_chan.ready = !q_full && !clearing;
  assign accept        = in_chan.valid && in_chan.ready;
  assign q_push        = accept && !wr_drop;

  always_comb begin
    q_data.kind = in_chan.action;
    q_data.va   = in_chan.virt_addr[pttw_pkg::VA_W-1:0];
    q_data.data = in_chan.entry_data;
    if (in_chan.action == pttw_pkg::KIND_XLATE) begin
      q_data.word = l1_word;
      q_data.oob  = (l1_word >= TW_EXT);
    end else begin
      q_data.word = wr_word;
      q_data.oob  = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pttw_queue.sv =====
// Short request queue between the front end and the walker.
`default_nettype none
module pttw_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  pttw_pkg::req_t push_data,
  output logic           full,
  input  wire logic      pop,
  output pttw_pkg::req_t pop_data,
  output logic           not_empty
);

  pttw_pkg::req_t entries_r [pttw_pkg::QUEUE_DEPTH];
  logic [pttw_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [pttw_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [pttw_pkg::QPTR_W:0]   count_r;

  assign full      = (count_r == (pttw_pkg::QPTR_W+1)'(pttw_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pttw_back.sv =====
// Back end: table memory, clearing sweep, three-level walk and result register.
`default_nettype none
module pttw_back #(
  parameter int TABLE_WORDS = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  input  pttw_pkg::req_t q_data,
  output logic           q_pop,
  output logic           clearing,
  pttw_out_if.source     out_chan
);

  localparam int AW = $clog2(TABLE_WORDS);
  localparam logic [pttw_pkg::WORD_W-1:0] TW_EXT = pttw_pkg::WORD_W'(TABLE_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(TABLE_WORDS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  localparam logic [1:0] LVL_1 = 2'd1;
  localparam logic [1:0] LVL_2 = 2'd2;
  localparam logic [1:0] LVL_3 = 2'd3;

  logic [pttw_pkg::DESC_W-1:0] mem [TABLE_WORDS];
  logic [pttw_pkg::DESC_W-1:0] rd_data_r;

  logic [1:0] state_r, state_nxt;
  logic [1:0] level_r, level_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] cur_addr_r;
  logic [AW-1:0] rd_addr;
  logic [pttw_pkg::VA_W-1:0] va_r, va_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [pttw_pkg::PA_W-1:0] out_pa_r, out_pa_nxt;
  logic out_fault_r, out_fault_nxt;

  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic [pttw_pkg::DESC_W-1:0] mem_wd;

  logic out_free;
  logic [8:0] next_idx;
  logic [pttw_pkg::WORD_W-2:0] next_word;
  logic next_oob;
  logic fault_now;
  logic done_ok;
  logic [pttw_pkg::PA_W-1:0] walk_pa;

  assign clearing = (state_r == ST_CLEAR);
  assign out_free = !out_valid_r || out_chan.ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.phys_addr = out_pa_r;
  assign out_chan.fault     = out_fault_r;

  always_comb begin
    unique case (level_r)
      LVL_1:   next_idx = va_r[29:21];
      default: next_idx = va_r[20:12];
    endcase
  end

  assign next_word = {rd_data_r[47:12], next_idx};
  assign next_oob  = ({1'b0, next_word} >= TW_EXT);
  assign fault_now = !rd_data_r[0] || ((level_r == LVL_3) && !rd_data_r[1]) ||
                     ((level_r != LVL_3) && rd_data_r[1] && next_oob);
  assign done_ok   = rd_data_r[0] && ((level_r == LVL_3) ? rd_data_r[1] : !rd_data_r[1]);

  always_comb begin
    unique case (level_r)
      LVL_1:   walk_pa = {rd_data_r[47:30], va_r[29:0]};
      LVL_2:   walk_pa = {rd_data_r[47:21], va_r[20:0]};
      default: walk_pa = {rd_data_r[47:12], va_r[11:0]};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    va_nxt        = va_r;
    rd_addr       = cur_addr_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = clr_cnt_r;
    mem_wd        = '0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_pa_nxt    = out_pa_r;
    out_fault_nxt = out_fault_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        q_pop = q_valid && ((q_data.kind == pttw_pkg::KIND_WRITE) || !q_data.oob || out_free);
        rd_addr = q_data.word[AW-1:0];
        if (q_pop) begin
          if (q_data.kind == pttw_pkg::KIND_WRITE) begin
            mem_we = 1'b1;
            mem_wa = q_data.word[AW-1:0];
            mem_wd = q_data.data;
          end else if (q_data.oob) begin
            out_valid_nxt = 1'b1;
            out_pa_nxt    = '0;
            out_fault_nxt = 1'b1;
          end else begin
            va_nxt    = q_data.va;
            level_nxt = LVL_1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!fault_now && !done_ok) begin
          rd_addr   = next_word[AW-1:0];
          level_nxt = level_r + 2'd1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pa_nxt    = fault_now ? '0 : walk_pa;
          out_fault_nxt = fault_now;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cur_addr_r <= rd_addr;
    va_r       <= va_nxt;
    out_pa_r   <= out_pa_nxt;
    out_fault_r <= out_fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      level_r     <= LVL_1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pttw_checker.sv =====
// Port-level checks for the page table walker, bound to the top level.
`default_nettype none
module pttw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [47:0] out_phys_addr,
  input wire logic        out_fault
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phys_addr) && $stable(out_fault))
    else $error("stalled result changed or dropped");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_phys_addr == 48'd0)
    else $error("faulting result carries a nonzero address");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready && !out_valid)
    else $error("requests taken or result shown during table clearing");

endmodule

bind page_table_walk_translate pttw_checker u_pttw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_phys_addr(out_chan.phys_addr),
  .out_fault    (out_chan.fault)
);
`default_nettype wire
